FILE: src/hri_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri_pkg
// Shared types and constants of the homography reprojection inlier test.
// ----------------------------------------------------------------------------
package hri_pkg;

    localparam int COEF_W     = 32;
    localparam int ERR_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // quotient bits kept by the divider and the left shift of the dividend
    localparam int QUO_W      = 42;
    localparam int DIV_SHIFT  = 21;
    localparam int PROJ_W     = 41;
    localparam int DIFF_W     = 43;
    localparam int SQ_IN_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_D = 3'd3,
        CFG_LIMIT  = 3'd4
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] COEF_A_RST = 64'h0100_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_B_RST = 64'h0;
    localparam logic [CFG_DATA_W-1:0] COEF_C_RST = 64'h0100_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_D_RST = 64'h0;
    localparam logic [ERR_W-1:0]      LIMIT_RST  = 48'd256;
    localparam logic [ERR_W-1:0]      ERR_MAX    = {ERR_W{1'b1}};
    localparam logic [PROJ_W-1:0]     PROJ_CAP   = {1'b1, {(PROJ_W-1){1'b0}}};

endpackage
`default_nettype wire

FILE: src/hri_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri interfaces
// Point beat, result beat and register write channels.
// ----------------------------------------------------------------------------
interface hri_pts_if #(parameter int CW = 20);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] src_x;
    logic signed [CW-1:0] src_y;
    logic signed [CW-1:0] dst_x;
    logic signed [CW-1:0] dst_y;
    modport source (output valid, src_x, src_y, dst_x, dst_y, input ready);
    modport sink (input valid, src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface hri_res_if;
    logic        valid;
    logic        ready;
    logic [47:0] sq_error;
    logic        is_inlier;
    logic        degenerate;
    modport source (output valid, sq_error, is_inlier, degenerate, input ready);
    modport sink (input valid, sq_error, is_inlier, degenerate, output ready);
endinterface

interface hri_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/homography_reprojection_inlier_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homography_reprojection_inlier_test
// Projects a source point through the homography and tests the squared
// distance to the destination point against the inlier threshold.
//
//   channel  dir  beat
//   pts      in   src_x, src_y, dst_x, dst_y
//   res      out  sq_error, is_inlier, degenerate
//   cfg      in   index, data (register write)
//
// one beat per cycle while not held; stages: products, sums, magnitudes,
// 43 divider stages, rounding, squares, output register
// the whole pipeline holds while the output register is full and not taken
// reset clears valid bits and loads the identity homography, threshold 256
// ----------------------------------------------------------------------------
module homography_reprojection_inlier_test #(
    parameter int COORD_WIDTH = 20
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hri_pts_if.sink    pts,
    hri_res_if.source  res,
    hri_cfg_if.sink    cfg
);
    import hri_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = COEF_W + CW;
    localparam int NW = CW + 26;
    localparam int DL = QUO_W + 1;

    logic [CFG_DATA_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [ERR_W-1:0]      limit_reg;
    logic                  adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= COEF_A_RST;
            coef_b_reg <= COEF_B_RST;
            coef_c_reg <= COEF_C_RST;
            coef_d_reg <= COEF_D_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_COEF_A: coef_a_reg <= cfg.data;
                CFG_COEF_B: coef_b_reg <= cfg.data;
                CFG_COEF_C: coef_c_reg <= cfg.data;
                CFG_COEF_D: coef_d_reg <= cfg.data;
                CFG_LIMIT:  limit_reg  <= cfg.data[ERR_W-1:0];
                default:    ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] h0, h1, h3, h4, h6, h7;
    logic signed [35:0]       h2s, h5s;
    assign h0  = $signed(coef_a_reg[63:32]);
    assign h1  = $signed(coef_a_reg[31:0]);
    assign h3  = $signed(coef_b_reg[31:0]);
    assign h4  = $signed(coef_c_reg[63:32]);
    assign h6  = $signed(coef_d_reg[63:32]);
    assign h7  = $signed(coef_d_reg[31:0]);
    assign h2s = $signed({coef_b_reg[63:32], 4'b0000});
    assign h5s = $signed({coef_c_reg[31:0], 4'b0000});

    // valid bits
    logic v_a_reg, v_b_reg, v_c_reg, v_e_reg, v_f_reg, v_g_reg;
    logic v_d_reg [0:DL-1];

    assign adv       = !v_g_reg || res.ready;
    assign pts.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
            v_g_reg <= 1'b0;
            for (int s = 0; s < DL; s++)
                v_d_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_a_reg    <= pts.valid;
            v_b_reg    <= v_a_reg;
            v_c_reg    <= v_b_reg;
            v_d_reg[0] <= v_c_reg;
            for (int s = 1; s < DL; s++)
                v_d_reg[s] <= v_d_reg[s-1];
            v_e_reg    <= v_d_reg[DL-1];
            v_f_reg    <= v_e_reg;
            v_g_reg    <= v_f_reg;
        end
    end

    // products
    logic signed [PW-1:0] p0_reg, p1_reg, p3_reg, p4_reg, p6_reg, p7_reg;
    logic signed [CW-1:0] tx_a_reg, ty_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg   <= PW'(h0 * pts.src_x);
            p1_reg   <= PW'(h1 * pts.src_y);
            p3_reg   <= PW'(h3 * pts.src_x);
            p4_reg   <= PW'(h4 * pts.src_y);
            p6_reg   <= PW'(h6 * pts.src_x);
            p7_reg   <= PW'(h7 * pts.src_y);
            tx_a_reg <= pts.dst_x;
            ty_a_reg <= pts.dst_y;
        end
    end

    // sums
    localparam logic signed [NW-1:0] DEN_ONE = {{(NW-37){1'b0}}, 1'b1, 36'b0};
    logic signed [NW-1:0] nx_reg, ny_reg, den_reg;
    logic signed [CW-1:0] tx_b_reg, ty_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg   <= NW'(p0_reg >>> 8) + NW'(p1_reg >>> 8) + NW'(h2s);
            ny_reg   <= NW'(p3_reg >>> 8) + NW'(p4_reg >>> 8) + NW'(h5s);
            den_reg  <= NW'(p6_reg >>> 8) + NW'(p7_reg >>> 8) + DEN_ONE;
            tx_b_reg <= tx_a_reg;
            ty_b_reg <= ty_a_reg;
        end
    end

    // magnitudes and signs
    logic [NW-1:0]        nxm_reg, nym_reg, dm_reg;
    logic                 sgx_c_reg, sgy_c_reg, zero_c_reg;
    logic signed [CW-1:0] tx_c_reg, ty_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nxm_reg    <= nx_reg[NW-1] ? NW'(-nx_reg) : nx_reg;
            nym_reg    <= ny_reg[NW-1] ? NW'(-ny_reg) : ny_reg;
            dm_reg     <= den_reg[NW-1] ? NW'(-den_reg) : den_reg;
            sgx_c_reg  <= nx_reg[NW-1] ^ den_reg[NW-1];
            sgy_c_reg  <= ny_reg[NW-1] ^ den_reg[NW-1];
            zero_c_reg <= den_reg == '0;
            tx_c_reg   <= tx_b_reg;
            ty_c_reg   <= ty_b_reg;
        end
    end

    // dividers and their side data
    logic [QUO_W-1:0] qx, qy;
    logic             satx, saty;

    hri_div_pipe #(.NW(NW)) u_div_x (
        .clk   (clk),
        .en    (adv),
        .n     (nxm_reg),
        .d     (dm_reg),
        .q     (qx),
        .sat   (satx)
    );

    hri_div_pipe #(.NW(NW)) u_div_y (
        .clk   (clk),
        .en    (adv),
        .n     (nym_reg),
        .d     (dm_reg),
        .q     (qy),
        .sat   (saty)
    );

    logic                 sgx_d_reg  [0:DL-1];
    logic                 sgy_d_reg  [0:DL-1];
    logic                 zero_d_reg [0:DL-1];
    logic signed [CW-1:0] tx_d_reg   [0:DL-1];
    logic signed [CW-1:0] ty_d_reg   [0:DL-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sgx_d_reg[0]  <= sgx_c_reg;
            sgy_d_reg[0]  <= sgy_c_reg;
            zero_d_reg[0] <= zero_c_reg;
            tx_d_reg[0]   <= tx_c_reg;
            ty_d_reg[0]   <= ty_c_reg;
            for (int s = 1; s < DL; s++)
            begin
                sgx_d_reg[s]  <= sgx_d_reg[s-1];
                sgy_d_reg[s]  <= sgy_d_reg[s-1];
                zero_d_reg[s] <= zero_d_reg[s-1];
                tx_d_reg[s]   <= tx_d_reg[s-1];
                ty_d_reg[s]   <= ty_d_reg[s-1];
            end
        end
    end

    // rounding, clamp and difference
    logic [QUO_W:0]            rx_sum, ry_sum;
    logic [QUO_W-1:0]          rx, ry;
    logic [PROJ_W-1:0]         pmx, pmy;
    logic signed [DIFF_W-1:0]  psx, psy, tsx, tsy;
    logic signed [DIFF_W-1:0]  ex_reg, ey_reg;
    logic                      zero_e_reg;

    assign rx_sum = {1'b0, qx} + 1'b1;
    assign ry_sum = {1'b0, qy} + 1'b1;
    assign rx     = rx_sum[QUO_W:1];
    assign ry     = ry_sum[QUO_W:1];
    assign pmx    = (satx || rx > QUO_W'(PROJ_CAP)) ? PROJ_CAP : rx[PROJ_W-1:0];
    assign pmy    = (saty || ry > QUO_W'(PROJ_CAP)) ? PROJ_CAP : ry[PROJ_W-1:0];
    assign psx    = $signed({2'b00, pmx});
    assign psy    = $signed({2'b00, pmy});
    assign tsx    = DIFF_W'(tx_d_reg[DL-1]);
    assign tsy    = DIFF_W'(ty_d_reg[DL-1]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg     <= sgx_d_reg[DL-1] ? (-psx - tsx) : (psx - tsx);
            ey_reg     <= sgy_d_reg[DL-1] ? (-psy - tsy) : (psy - tsy);
            zero_e_reg <= zero_d_reg[DL-1];
        end
    end

    // squares
    logic [DIFF_W-1:0]  ax, ay;
    logic [ERR_W-1:0]   sqx_reg, sqy_reg;
    logic               big_f_reg, zero_f_reg;

    assign ax = ex_reg[DIFF_W-1] ? DIFF_W'(-ex_reg) : ex_reg;
    assign ay = ey_reg[DIFF_W-1] ? DIFF_W'(-ey_reg) : ey_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg    <= ax[SQ_IN_W-1:0] * ax[SQ_IN_W-1:0];
            sqy_reg    <= ay[SQ_IN_W-1:0] * ay[SQ_IN_W-1:0];
            big_f_reg  <= (|ax[DIFF_W-1:SQ_IN_W]) || (|ay[DIFF_W-1:SQ_IN_W]);
            zero_f_reg <= zero_e_reg;
        end
    end

    // sum, saturation, threshold; output register
    logic [ERR_W:0]   sq_sum;
    logic [ERR_W-1:0] err;
    logic [ERR_W-1:0] err_reg;
    logic             inl_reg, deg_reg;

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign err    = (zero_f_reg || big_f_reg || sq_sum[ERR_W]) ? ERR_MAX : sq_sum[ERR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg <= err;
            inl_reg <= !zero_f_reg && (err <= limit_reg);
            deg_reg <= zero_f_reg;
        end
    end

    assign res.valid      = v_g_reg;
    assign res.sq_error   = err_reg;
    assign res.is_inlier  = inl_reg;
    assign res.degenerate = deg_reg;

endmodule
`default_nettype wire

FILE: src/hri_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri_div_pipe
// Restoring divider, one quotient bit per stage, for (n << 21) / d.
// ----------------------------------------------------------------------------
module hri_div_pipe #(
    parameter int NW = 46
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [NW-1:0]              n,
    input  wire logic [NW-1:0]              d,
    output logic [hri_pkg::QUO_W-1:0]       q,
    output logic                            sat
);
    import hri_pkg::*;

    logic [NW-1:0]    rem_reg [0:QUO_W];
    logic [NW-1:0]    n_reg   [0:QUO_W];
    logic [NW-1:0]    d_reg   [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             sat_reg [0:QUO_W];
    logic [NW-1:0]    rem_next [1:QUO_W];
    logic [QUO_W-1:0] q_next   [1:QUO_W];
    logic             sat_next;

    // quotient of 2^42 or more saturates the projection
    assign sat_next = {{DIV_SHIFT{1'b0}}, n} >= {d, {DIV_SHIFT{1'b0}}};

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            localparam int I = QUO_W - 1 - k;
            logic          din;
            logic [NW:0]   sh;
            logic          ge;
            if (I >= DIV_SHIFT)
            begin : g_bit
                assign din = n_reg[k][I-DIV_SHIFT];
            end
            else
            begin : g_zero
                assign din = 1'b0;
            end
            assign sh = {rem_reg[k], din};
            assign ge = sh >= {1'b0, d_reg[k]};
            assign rem_next[k+1] = ge ? NW'(sh - {1'b0, d_reg[k]}) : sh[NW-1:0];
            assign q_next[k+1]   = {q_reg[k][QUO_W-2:0], ge};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= NW'(n >> DIV_SHIFT);
            n_reg[0]   <= n;
            d_reg[0]   <= d;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_next;
            for (int s = 1; s <= QUO_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                n_reg[s]   <= n_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                q_reg[s]   <= q_next[s];
                sat_reg[s] <= sat_reg[s-1];
            end
        end
    end

    assign q   = q_reg[QUO_W];
    assign sat = sat_reg[QUO_W];

endmodule
`default_nettype wire
